### sv/msmi_pkg.sv
package msmi_pkg;

    localparam int DIM    = 8;
    localparam int IDX_W  = $clog2(DIM);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DATA_W = 32;
    localparam int ACC_W  = 64;
    localparam int ITER_W = 8;
    localparam int SIZE_W = 4;
    localparam int KIND_W = 3;
    localparam int CFG_W  = 8;

    localparam logic [KIND_W-1:0] KIND_LOAD_A  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_X  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MISSING = 3'd2;
    localparam logic [KIND_W-1:0] KIND_START   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ    = 3'd4;

    localparam logic RESP_DONE = 1'b0;
    localparam logic RESP_READ = 1'b1;

    localparam logic REG_ITER = 1'b0;
    localparam logic REG_SIZE = 1'b1;

    localparam logic [ITER_W-1:0] ITER_RESET = 8'd1;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    localparam logic signed [DATA_W:0]  TWO_Q16    = 33'sd131072;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 64'sd32768;
    localparam int FRAC_W = 16;

    typedef struct packed {
        logic             ld_a;
        logic             ld_x;
        logic             ld_m;
        logic             zero_we;
        logic             copy_we;
        logic             rd_x;
        logic             mac;
        logic             first;
        logic             last;
        logic             phase;
        logic             sat_clr;
        logic             out_load;
        logic             out_resp;
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        logic [IDX_W-1:0] k;
    } msmi_cmd_t;

endpackage

### sv/msmi_item_if.sv
interface msmi_item_if;
    import msmi_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, kind, row_index, col_index, value, input ready);
    modport sink   (input valid, kind, row_index, col_index, value, output ready);
endinterface

### sv/msmi_result_if.sv
interface msmi_result_if;
    import msmi_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     response;
    logic signed [DATA_W-1:0] data;
    logic                     saturated;

    modport source (output valid, response, data, saturated, input ready);
    modport sink   (input valid, response, data, saturated, output ready);
endinterface

### sv/msmi_datapath.sv
module msmi_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  msmi_pkg::msmi_cmd_t               cmd,
    input  logic signed [msmi_pkg::DATA_W-1:0] value,
    output logic                              response,
    output logic signed [msmi_pkg::DATA_W-1:0] data,
    output logic                              saturated
);
    import msmi_pkg::*;

    logic signed [DATA_W-1:0] a_mem [DIM*DIM];
    logic signed [DATA_W-1:0] x_mem [DIM*DIM];
    logic signed [DATA_W-1:0] p_mem [DIM*DIM];
    logic signed [DATA_W-1:0] a_rd_reg, x_rd_reg, p_rd_reg;
    logic signed [DATA_W-1:0] rowbuf_reg [DIM];

    logic [DIM-1:0] missing_reg;
    logic           sat_reg, sat_next;

    logic [ADDR_W-1:0]        a_ra, x_ra, p_ra, x_wa;
    logic                     x_we;
    logic signed [DATA_W-1:0] x_wd;

    // pipeline tags
    logic             s1_v_reg, s1_first_reg, s1_last_reg, s1_phase_reg;
    logic [IDX_W-1:0] s1_r_reg, s1_c_reg;
    logic             s2_v_reg, s2_first_reg, s2_last_reg, s2_phase_reg;
    logic [IDX_W-1:0] s2_r_reg, s2_c_reg;
    logic             s3_v_reg, s3_last_reg, s3_phase_reg;
    logic [IDX_W-1:0] s3_r_reg, s3_c_reg;

    logic signed [ACC_W-1:0] prod_reg, acc_reg, acc_next, acc_sum;
    logic                    acc_ovf;
    logic signed [ACC_W-1:0] rnd_sum, rnd_val, shifted;
    logic                    rnd_ovf, q_ovf, d_ovf;
    logic signed [DATA_W-1:0] q32, d32;
    logic signed [DATA_W:0]   diff;

    logic             resp_reg;
    logic signed [DATA_W-1:0] data_reg;
    logic             osat_reg;

    always_comb
    begin
        a_ra = {cmd.r, cmd.k};
        p_ra = {cmd.k, cmd.c};
        if (cmd.mac && !cmd.phase)
            x_ra = {cmd.k, cmd.c};
        else if (cmd.mac)
            x_ra = {cmd.r, cmd.k};
        else
            x_ra = {cmd.r, cmd.c};

        x_wa = {cmd.r, cmd.c};
        x_we = 1'b0;
        x_wd = value;
        if (cmd.ld_x)
            x_we = 1'b1;
        else if (cmd.zero_we)
        begin
            x_we = missing_reg[cmd.r] | missing_reg[cmd.c];
            x_wd = '0;
        end
        else if (cmd.copy_we)
        begin
            x_we = 1'b1;
            x_wd = rowbuf_reg[cmd.c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_a)
            a_mem[{cmd.r, cmd.c}] <= value;
        a_rd_reg <= a_mem[a_ra];
    end

    always_ff @(posedge clk)
    begin
        if (x_we)
            x_mem[x_wa] <= x_wd;
        x_rd_reg <= x_mem[x_ra];
    end

    always_ff @(posedge clk)
    begin
        if (s3_v_reg && s3_last_reg && !s3_phase_reg)
            p_mem[{s3_r_reg, s3_c_reg}] <= d32;
        p_rd_reg <= p_mem[p_ra];
    end

    always_ff @(posedge clk)
    begin
        if (s3_v_reg && s3_last_reg && s3_phase_reg)
            rowbuf_reg[s3_c_reg] <= q32;
    end

    // saturating accumulate
    always_comb
    begin
        acc_sum = acc_reg + prod_reg;
        acc_ovf = (acc_reg[ACC_W-1] == prod_reg[ACC_W-1])
                  && (acc_sum[ACC_W-1] != acc_reg[ACC_W-1]);
        if (s2_first_reg)
            acc_next = prod_reg;
        else if (acc_ovf)
            acc_next = acc_reg[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                        : {1'b0, {(ACC_W-1){1'b1}}};
        else
            acc_next = acc_sum;
    end

    // round to nearest, saturate, then 2I - v for the first product
    always_comb
    begin
        rnd_sum = acc_reg + ROUND_HALF;
        rnd_ovf = !acc_reg[ACC_W-1] && rnd_sum[ACC_W-1];
        rnd_val = rnd_ovf ? {1'b0, {(ACC_W-1){1'b1}}} : rnd_sum;
        shifted = rnd_val >>> FRAC_W;
        q_ovf   = !((&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1]));
        if (q_ovf)
            q32 = shifted[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                   : {1'b0, {(DATA_W-1){1'b1}}};
        else
            q32 = shifted[DATA_W-1:0];
        diff  = ((s3_r_reg == s3_c_reg) ? TWO_Q16 : '0) - {q32[DATA_W-1], q32};
        d_ovf = diff[DATA_W] != diff[DATA_W-1];
        if (d_ovf)
            d32 = diff[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                               : {1'b0, {(DATA_W-1){1'b1}}};
        else
            d32 = diff[DATA_W-1:0];

        sat_next = sat_reg;
        if (s2_v_reg && !s2_first_reg && acc_ovf)
            sat_next = 1'b1;
        if (s3_v_reg && s3_last_reg && (rnd_ovf || q_ovf || (!s3_phase_reg && d_ovf)))
            sat_next = 1'b1;
        if (cmd.sat_clr)
            sat_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            missing_reg <= '0;
            sat_reg     <= 1'b0;
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            s3_v_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.ld_m)
                missing_reg[cmd.r] <= value[0];
            sat_reg  <= sat_next;
            s1_v_reg <= cmd.mac;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= cmd.first;
        s1_last_reg  <= cmd.last;
        s1_phase_reg <= cmd.phase;
        s1_r_reg     <= cmd.r;
        s1_c_reg     <= cmd.c;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_phase_reg <= s1_phase_reg;
        s2_r_reg     <= s1_r_reg;
        s2_c_reg     <= s1_c_reg;
        s3_last_reg  <= s2_last_reg;
        s3_phase_reg <= s2_phase_reg;
        s3_r_reg     <= s2_r_reg;
        s3_c_reg     <= s2_c_reg;
        if (s1_phase_reg)
            prod_reg <= x_rd_reg * p_rd_reg;
        else
            prod_reg <= a_rd_reg * x_rd_reg;
        if (s2_v_reg)
            acc_reg <= acc_next;
        if (cmd.out_load)
        begin
            resp_reg <= cmd.out_resp;
            data_reg <= (cmd.out_resp == RESP_READ) ? x_rd_reg : '0;
            osat_reg <= sat_reg;
        end
    end

    assign response  = resp_reg;
    assign data      = data_reg;
    assign saturated = osat_reg;

endmodule

### sv/msmi_ctrl.sv
module msmi_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  logic [msmi_pkg::KIND_W-1:0]     kind,
    input  logic [msmi_pkg::IDX_W-1:0]      row_index,
    input  logic [msmi_pkg::IDX_W-1:0]      col_index,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [msmi_pkg::CFG_W-1:0]      cfg_data,
    output logic                            result_valid,
    input  logic                            result_ready,
    output msmi_pkg::msmi_cmd_t             cmd
);
    import msmi_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD1  = 4'd1;
    localparam logic [3:0] ST_RD2  = 4'd2;
    localparam logic [3:0] ST_ZERO = 4'd3;
    localparam logic [3:0] ST_MUL1 = 4'd4;
    localparam logic [3:0] ST_DRN1 = 4'd5;
    localparam logic [3:0] ST_MUL2 = 4'd6;
    localparam logic [3:0] ST_DRN2 = 4'd7;
    localparam logic [3:0] ST_COPY = 4'd8;
    localparam logic [3:0] ST_DONE = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [IDX_W-1:0]  r_reg, r_next, c_reg, c_next, k_reg, k_next;
    logic [SIZE_W-1:0] n_reg, n_next;
    logic [ITER_W-1:0] it_reg, it_next, iter_reg, iter_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [1:0]        drn_reg, drn_next;
    logic              out_valid_reg, out_valid_next;
    logic [SIZE_W-1:0] nm1_w;
    logic [IDX_W-1:0]  nm1;
    logic              accept, r_last, c_last, k_last;

    always_comb
    begin
        nm1_w  = n_reg - 1'b1;
        nm1    = nm1_w[IDX_W-1:0];
        r_last = r_reg == nm1;
        c_last = c_reg == nm1;
        k_last = k_reg == nm1;

        state_next = state_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        it_next    = it_reg;
        drn_next   = drn_reg;
        iter_next  = iter_reg;
        size_next  = size_reg;

        cmd       = '0;
        cmd.r     = r_reg;
        cmd.c     = c_reg;
        cmd.k     = k_reg;

        item_ready = (state_reg == ST_IDLE) && !out_valid_reg;
        accept     = item_valid && item_ready;

        if (cfg_we)
        begin
            if (cfg_index == REG_ITER)
                iter_next = cfg_data[ITER_W-1:0];
            else
                size_next = cfg_data[SIZE_W-1:0];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.r = row_index;
                    cmd.c = col_index;
                    unique case (kind)
                        KIND_LOAD_A:  cmd.ld_a = 1'b1;
                        KIND_LOAD_X:  cmd.ld_x = 1'b1;
                        KIND_MISSING: cmd.ld_m = 1'b1;
                        KIND_START:
                        begin
                            cmd.sat_clr = 1'b1;
                            if (size_reg == '0)
                                n_next = SIZE_W'(1);
                            else if (size_reg > SIZE_W'(DIM))
                                n_next = SIZE_W'(DIM);
                            else
                                n_next = size_reg;
                            r_next     = '0;
                            c_next     = '0;
                            it_next    = '0;
                            state_next = ST_ZERO;
                        end
                        KIND_READ:
                        begin
                            r_next     = row_index;
                            c_next     = col_index;
                            state_next = ST_RD1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD1:
            begin
                cmd.rd_x   = 1'b1;
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                cmd.out_load = 1'b1;
                cmd.out_resp = RESP_READ;
                state_next   = ST_IDLE;
            end
            ST_ZERO:
            begin
                cmd.zero_we = 1'b1;
                c_next      = c_reg + 1'b1;
                if (c_last)
                begin
                    c_next = '0;
                    r_next = r_reg + 1'b1;
                    if (r_last)
                    begin
                        r_next     = '0;
                        k_next     = '0;
                        state_next = (iter_reg == '0) ? ST_DONE : ST_MUL1;
                    end
                end
            end
            ST_MUL1, ST_MUL2:
            begin
                cmd.mac   = 1'b1;
                cmd.phase = state_reg == ST_MUL2;
                cmd.first = k_reg == '0;
                cmd.last  = k_last;
                k_next    = k_reg + 1'b1;
                if (k_last)
                begin
                    k_next = '0;
                    c_next = c_reg + 1'b1;
                    if (c_last)
                    begin
                        c_next   = '0;
                        drn_next = '0;
                        if (state_reg == ST_MUL2)
                            state_next = ST_DRN2;
                        else
                        begin
                            r_next = r_reg + 1'b1;
                            if (r_last)
                            begin
                                r_next     = '0;
                                state_next = ST_DRN1;
                            end
                        end
                    end
                end
            end
            ST_DRN1, ST_DRN2:
            begin
                drn_next = drn_reg + 1'b1;
                if (drn_reg == 2'd2)
                    state_next = (state_reg == ST_DRN1) ? ST_MUL2 : ST_COPY;
            end
            ST_COPY:
            begin
                cmd.copy_we = 1'b1;
                c_next      = c_reg + 1'b1;
                if (c_last)
                begin
                    c_next = '0;
                    k_next = '0;
                    r_next = r_reg + 1'b1;
                    state_next = ST_MUL2;
                    if (r_last)
                    begin
                        r_next  = '0;
                        it_next = it_reg + 1'b1;
                        state_next = (it_next == iter_reg) ? ST_DONE : ST_MUL1;
                    end
                end
            end
            ST_DONE:
            begin
                cmd.out_load = 1'b1;
                cmd.out_resp = RESP_DONE;
                state_next   = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase

        out_valid_next = out_valid_reg && !result_ready;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            r_reg         <= '0;
            c_reg         <= '0;
            k_reg         <= '0;
            n_reg         <= SIZE_W'(DIM);
            it_reg        <= '0;
            drn_reg       <= '0;
            iter_reg      <= ITER_RESET;
            size_reg      <= SIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            it_reg        <= it_next;
            drn_reg       <= drn_next;
            iter_reg      <= iter_next;
            size_reg      <= size_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

### sv/masked_schulz_matrix_inverse.sv
// channel  | dir | payload
// item     | in  | kind, row_index, col_index, value
// result   | out | response, data, saturated
// cfg      | in  | cfg_we, cfg_index, cfg_data (write only)
//
// Loads and flag writes are done when accepted; a read passes the RD1 and RD2
// states and then registers its data. A start first zeroes the masked entries
// of X, then each iteration forms P = 2I - A*X and X*P, row by row, on the single
// multiply-accumulate unit.
// One request at a time: item is not taken while a result waits.
// rst_n clears control state and missing flags; stores hold no reset.
module masked_schulz_matrix_inverse (
    input  logic                        clk,
    input  logic                        rst_n,
    msmi_item_if.sink                   item,
    msmi_result_if.source               result,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [msmi_pkg::CFG_W-1:0]  cfg_data
);
    import msmi_pkg::*;

    msmi_cmd_t cmd;

    msmi_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .kind         (item.kind),
        .row_index    (item.row_index),
        .col_index    (item.col_index),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd)
    );

    msmi_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .value     (item.value),
        .response  (result.response),
        .data      (result.data),
        .saturated (result.saturated)
    );

endmodule
